// File: sv/utv_pkg.sv
package utv_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LIMIT_W = 10;
	localparam int unsigned TALLY_W = 11;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS = 2'd1;

	localparam logic [LIMIT_W-1:0] MAX_BYTES_RST = 10'd64;
	localparam logic [LIMIT_W-1:0] MAX_CHARS_RST = 10'd32;

	// lead and continuation byte codes
	localparam logic [BYTE_W-1:0] ASCII_LAST  = 8'h7F;
	localparam logic [BYTE_W-1:0] LEAD2_FIRST = 8'hC2;
	localparam logic [BYTE_W-1:0] LEAD2_LAST  = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_FIRST = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_LAST  = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_FIRST = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_LAST  = 8'hF4;
	localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_TAG    = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD_SURR   = 8'hED;
	localparam logic [BYTE_W-1:0] SEC3_SPLIT  = 8'hA0;
	localparam logic [BYTE_W-1:0] SEC4_SPLIT  = 8'h90;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              is_final;
	} in_item_t;

	typedef struct packed {
		logic               text_ok;
		logic [LIMIT_W-1:0] char_total;
	} out_item_t;

	typedef struct packed {
		logic               failed;
		logic [1:0]         bytes_pending;
		logic [BYTE_W-1:0]  lead_value;
		logic               expect_second;
		logic [TALLY_W-1:0] byte_tally;
		logic [TALLY_W-1:0] char_tally;
	} scan_state_t;

endpackage

// File: sv/utv_decode.sv
module utv_decode (
	input  utv_pkg::scan_state_t          cur,
	input  logic [utv_pkg::BYTE_W-1:0]    text_byte,
	output utv_pkg::scan_state_t          nxt
);
	import utv_pkg::*;

	logic count_char;
	logic second_ok;

	always_comb begin
		second_ok = 1'b1;
		if (cur.lead_value == LEAD3_FIRST && text_byte < SEC3_SPLIT) second_ok = 1'b0;
		if (cur.lead_value == LEAD_SURR && text_byte >= SEC3_SPLIT) second_ok = 1'b0;
		if (cur.lead_value == LEAD4_FIRST && text_byte < SEC4_SPLIT) second_ok = 1'b0;
		if (cur.lead_value == LEAD4_LAST && text_byte >= SEC4_SPLIT) second_ok = 1'b0;
	end

	always_comb begin
		nxt = cur;
		count_char = 1'b0;
		if (cur.byte_tally != TALLY_MAX) begin
			nxt.byte_tally = cur.byte_tally + 1'b1;
		end
		if (!cur.failed) begin
			if (cur.bytes_pending == 2'd0) begin
				nxt.lead_value = text_byte;
				if (text_byte <= ASCII_LAST) begin
					count_char = 1'b1;
				end else if (text_byte >= LEAD2_FIRST && text_byte <= LEAD2_LAST) begin
					nxt.bytes_pending = 2'd1;
					nxt.expect_second = 1'b0;
				end else if (text_byte >= LEAD3_FIRST && text_byte <= LEAD3_LAST) begin
					nxt.bytes_pending = 2'd2;
					nxt.expect_second = 1'b1;
				end else if (text_byte >= LEAD4_FIRST && text_byte <= LEAD4_LAST) begin
					nxt.bytes_pending = 2'd3;
					nxt.expect_second = 1'b1;
				end else begin
					nxt.failed = 1'b1;
				end
			end else if ((text_byte & CONT_MASK) != CONT_TAG) begin
				nxt.failed = 1'b1;
			end else if (cur.expect_second && !second_ok) begin
				nxt.expect_second = 1'b0;
				nxt.failed = 1'b1;
			end else begin
				nxt.expect_second = 1'b0;
				nxt.bytes_pending = cur.bytes_pending - 2'd1;
				count_char = (cur.bytes_pending == 2'd1);
			end
		end
		if (count_char && cur.char_tally != TALLY_MAX) begin
			nxt.char_tally = cur.char_tally + 1'b1;
		end
	end

endmodule

// File: sv/utv_verdict.sv
module utv_verdict (
	input  utv_pkg::scan_state_t          st,
	input  logic [utv_pkg::LIMIT_W-1:0]   max_bytes,
	input  logic [utv_pkg::LIMIT_W-1:0]   max_chars,
	output utv_pkg::out_item_t            res
);
	import utv_pkg::*;

	logic ok;

	// limits compare against the saturating tallies after this byte
	assign ok = !st.failed && (st.bytes_pending == 2'd0)
		&& (st.byte_tally <= {1'b0, max_bytes})
		&& (st.char_tally <= {1'b0, max_chars});

	assign res.text_ok    = ok;
	assign res.char_total = ok ? st.char_tally[LIMIT_W-1:0] : '0;

endmodule

// File: sv/utf8_text_validator_core.sv
// channel | direction | handshake            | payload
// in      | to core   | in_valid / in_ready   | in_data  (text_byte, is_final)
// out     | from core | out_valid / out_ready | out_data (text_ok, char_total)
// cfg     | to core   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one byte per cycle while no final byte is held back: a request is registered, then decoded
// from that register, and a final byte's verdict is written to the output register as it advances.
// reset clears the scan state, the valid flags and sets both limits to defaults.
// a held result stalls only final bytes; other bytes keep flowing past it.
// cfg_ready is always high.
module utf8_text_validator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  utv_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output utv_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [utv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [utv_pkg::LIMIT_W-1:0]     cfg_data
);
	import utv_pkg::*;

	logic               valid_s1;
	in_item_t           item_s1;
	scan_state_t        state_q;
	scan_state_t        state_next;
	logic [LIMIT_W-1:0] max_bytes_q;
	logic [LIMIT_W-1:0] max_chars_q;
	logic               out_valid_q;
	out_item_t          out_data_q;
	out_item_t          verdict;
	logic               advance;
	logic               finish;

	assign cfg_ready = 1'b1;

	// a final byte waits only if the output register is still held
	assign advance  = valid_s1 && (!item_s1.is_final || !out_valid_q || out_ready);
	assign finish   = advance && item_s1.is_final;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RST;
			max_chars_q <= MAX_CHARS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_BYTES: max_bytes_q <= cfg_data;
				CFG_MAX_CHARS: max_chars_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	utv_decode u_decode (
		.cur       (state_q),
		.text_byte (item_s1.text_byte),
		.nxt       (state_next)
	);

	utv_verdict u_verdict (
		.st        (state_next),
		.max_bytes (max_bytes_q),
		.max_chars (max_chars_q),
		.res       (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (finish) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_fail_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.text_ok |-> out_data.char_total == '0)
		else $error("invalid string reported with nonzero count");

	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> state_q.byte_tally == '0 && state_q.bytes_pending == 2'd0)
		else $error("scan state not cleared after final byte");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(finish))
		else $error("result appeared without a final byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && item_s1.is_final && out_valid_q && !out_ready)
		else $error("input stalled without a held result");

endmodule

// File: bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import utv_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;

	localparam logic [BYTE_W-1:0] CONT_LAST = 8'hBF;
	localparam logic [BYTE_W-1:0] OVERLONG_LEAD_LAST = 8'hC1;
	localparam logic [BYTE_W-1:0] BYTE_LAST = 8'hFF;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_BYTES;
	logic [LIMIT_W-1:0] cfg_data = '0;

	utf8_text_validator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	in_item_t byte_plan_q[$];
	out_item_t verdict_q[$];
	logic [BYTE_W-1:0] text_buf[$];

	scan_state_t scan = '0;
	logic [LIMIT_W-1:0] byte_limit = MAX_BYTES_RST;
	logic [LIMIT_W-1:0] char_limit = MAX_CHARS_RST;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	logic in_sent = 1'b0;

	function automatic logic [BYTE_W-1:0] rand_byte(input int unsigned hi,
			input int unsigned lo);
		return BYTE_W'($urandom_range(hi, lo));
	endfunction

	// utf-8 decode of one accepted byte; a final byte yields the verdict
	function void scan_text_byte(input in_item_t item);
		logic [BYTE_W-1:0] b;
		logic bad;
		out_item_t verdict;
		b = item.text_byte;
		if (scan.byte_tally != TALLY_MAX)
			scan.byte_tally++;
		if (!scan.failed) begin
			if (scan.bytes_pending == 2'd0) begin
				scan.lead_value = b;
				if (b <= ASCII_LAST) begin
					if (scan.char_tally != TALLY_MAX)
						scan.char_tally++;
				end else if (b >= LEAD2_FIRST && b <= LEAD2_LAST) begin
					scan.bytes_pending = 2'd1;
					scan.expect_second = 1'b0;
				end else if (b >= LEAD3_FIRST && b <= LEAD3_LAST) begin
					scan.bytes_pending = 2'd2;
					scan.expect_second = 1'b1;
				end else if (b >= LEAD4_FIRST && b <= LEAD4_LAST) begin
					scan.bytes_pending = 2'd3;
					scan.expect_second = 1'b1;
				end else begin
					scan.failed = 1'b1;
				end
			end else if ((b & CONT_MASK) != CONT_TAG) begin
				scan.failed = 1'b1;
			end else begin
				bad = 1'b0;
				if (scan.expect_second) begin
					scan.expect_second = 1'b0;
					// overlong forms, surrogates and code points above the unicode range
					bad = (scan.lead_value == LEAD3_FIRST && b < SEC3_SPLIT) ||
						(scan.lead_value == LEAD_SURR && b >= SEC3_SPLIT) ||
						(scan.lead_value == LEAD4_FIRST && b < SEC4_SPLIT) ||
						(scan.lead_value == LEAD4_LAST && b >= SEC4_SPLIT);
				end
				if (bad) begin
					scan.failed = 1'b1;
				end else begin
					scan.bytes_pending = scan.bytes_pending - 2'd1;
					if (scan.bytes_pending == 2'd0 && scan.char_tally != TALLY_MAX)
						scan.char_tally++;
				end
			end
		end
		if (item.is_final) begin
			verdict.text_ok = !scan.failed && scan.bytes_pending == 2'd0 &&
				scan.byte_tally <= byte_limit && scan.char_tally <= char_limit;
			verdict.char_total = verdict.text_ok ? scan.char_tally[LIMIT_W-1:0] : '0;
			verdict_q.push_back(verdict);
			scan = '0;
		end
	endfunction

	task report_error(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("error at %0t: %s", $realtime, what);
	endtask

	// driver: next byte goes out at the falling edge once the last one was taken
	always @(posedge clk) begin
		in_sent <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			scan_text_byte(in_data);
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_sent)) begin
			if (byte_plan_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				in_data <= byte_plan_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		out_ready <= arst_n && ($urandom_range(99, 0) >= recv_stall_pct);

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				report_error($sformatf("unexpected result ok=%0b chars=%0d",
					out_data.text_ok, out_data.char_total));
			end else begin
				want = verdict_q.pop_front();
				if (out_data.text_ok !== want.text_ok)
					report_error($sformatf("text_ok expected %0b got %0b",
						want.text_ok, out_data.text_ok));
				if (out_data.char_total !== want.char_total)
					report_error($sformatf("char_total expected %0d got %0d",
						want.char_total, out_data.char_total));
			end
		end
	end

	// watchdog on cycles with no request moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("timeout: no progress for %0d cycles", QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_MAX_BYTES)
			byte_limit = value;
		else if (idx == CFG_MAX_CHARS)
			char_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task wait_drained;
		while (byte_plan_q.size() != 0 || in_valid || verdict_q.size() != 0)
			@(posedge clk);
		// bytes with no result may still sit in the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function void queue_text;
		in_item_t item;
		for (int i = 0; i < text_buf.size(); i++) begin
			item.text_byte = text_buf[i];
			item.is_final = (i == text_buf.size() - 1);
			byte_plan_q.push_back(item);
		end
		text_buf.delete();
	endfunction

	function void append_char;
		logic [BYTE_W-1:0] lead;
		case ($urandom_range(3, 0))
			0: text_buf.push_back(rand_byte(ASCII_LAST, 1));
			1: begin
				text_buf.push_back(rand_byte(LEAD2_LAST, LEAD2_FIRST));
				text_buf.push_back(rand_byte(CONT_LAST, CONT_TAG));
			end
			2: begin
				lead = rand_byte(LEAD3_LAST, LEAD3_FIRST);
				text_buf.push_back(lead);
				if (lead == LEAD3_FIRST)
					text_buf.push_back(rand_byte(CONT_LAST, SEC3_SPLIT));
				else if (lead == LEAD_SURR)
					text_buf.push_back(rand_byte(SEC3_SPLIT - 1, CONT_TAG));
				else
					text_buf.push_back(rand_byte(CONT_LAST, CONT_TAG));
				text_buf.push_back(rand_byte(CONT_LAST, CONT_TAG));
			end
			default: begin
				lead = rand_byte(LEAD4_LAST, LEAD4_FIRST);
				text_buf.push_back(lead);
				if (lead == LEAD4_FIRST)
					text_buf.push_back(rand_byte(CONT_LAST, SEC4_SPLIT));
				else if (lead == LEAD4_LAST)
					text_buf.push_back(rand_byte(SEC4_SPLIT - 1, CONT_TAG));
				else
					text_buf.push_back(rand_byte(CONT_LAST, CONT_TAG));
				repeat (2) text_buf.push_back(rand_byte(CONT_LAST, CONT_TAG));
			end
		endcase
	endfunction

	function void append_bad_pair;
		case ($urandom_range(3, 0))
			0: begin
				text_buf.push_back(LEAD3_FIRST);
				text_buf.push_back(rand_byte(SEC3_SPLIT - 1, CONT_TAG));
			end
			1: begin
				text_buf.push_back(LEAD_SURR);
				text_buf.push_back(rand_byte(CONT_LAST, SEC3_SPLIT));
			end
			2: begin
				text_buf.push_back(LEAD4_FIRST);
				text_buf.push_back(rand_byte(SEC4_SPLIT - 1, CONT_TAG));
			end
			default: begin
				text_buf.push_back(LEAD4_LAST);
				text_buf.push_back(rand_byte(CONT_LAST, SEC4_SPLIT));
			end
		endcase
		text_buf.push_back(rand_byte(CONT_LAST, CONT_TAG));
	endfunction

	// mostly well-formed text, some of it damaged, now and then plain noise
	function int queue_random_text(input int char_hi);
		int n;
		int pos;
		int len;
		if ($urandom_range(19, 0) == 0) begin
			repeat ($urandom_range(12, 1)) text_buf.push_back(rand_byte(BYTE_LAST, 1));
		end else begin
			n = ($urandom_range(3, 0) == 0) ? $urandom_range(char_hi, 1) :
				$urandom_range((char_hi < 6) ? char_hi : 6, 1);
			repeat (n) append_char();
			if ($urandom_range(3, 0) == 0) begin
				pos = $urandom_range(text_buf.size() - 1, 0);
				case ($urandom_range(4, 0))
					0: text_buf[pos] = rand_byte(BYTE_LAST, 1);
					1: if (text_buf.size() > 1) void'(text_buf.pop_back());
					2: text_buf.insert(pos, rand_byte(OVERLONG_LEAD_LAST, 8'hC0));
					3: text_buf.insert(pos, ($urandom_range(1, 0) != 0) ?
						rand_byte(BYTE_LAST, LEAD4_LAST + 1) :
						rand_byte(CONT_LAST, CONT_TAG));
					default: begin
						append_bad_pair();
						if ($urandom_range(1, 0) != 0)
							append_char();
					end
				endcase
			end
		end
		len = text_buf.size();
		queue_text();
		return len;
	endfunction

	task run_random(input int send_pct, input int recv_pct, input int budget,
			input int char_hi);
		int planned;
		planned = 0;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		while (planned < budget)
			planned += queue_random_text(char_hi);
		wait_drained();
	endtask

	function void queue_ascii_run(input int n);
		repeat (n) text_buf.push_back(rand_byte(ASCII_LAST, 1));
		queue_text();
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed strings with the reset limits
		text_buf = '{8'h41};
		queue_text();
		// zero byte taken as a plain character
		text_buf = '{8'h00};
		queue_text();
		text_buf = '{8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
			8'hF4, 8'h8F, 8'hBF, 8'hBF};
		queue_text();
		// surrogate, then a continuation that must not be decoded after the error
		text_buf = '{8'hED, 8'hA0, 8'h80};
		queue_text();
		text_buf = '{8'hF0, 8'h8F};
		queue_text();
		// sequence cut short by the final byte
		text_buf = '{8'hE1, 8'h80};
		queue_text();
		text_buf = '{8'hFF};
		queue_text();
		text_buf = '{8'h80, 8'h41};
		queue_text();
		wait_drained();

		run_random(0, 0, 150, 40);

		write_reg(CFG_MAX_BYTES, 10'd48);
		write_reg(CFG_MAX_CHARS, 10'd48);
		send_idle_pct = 63;
		// one string right at both limits, one a byte over
		queue_ascii_run(48);
		queue_ascii_run(49);
		wait_drained();

		write_reg(CFG_MAX_BYTES, 10'd1023);
		write_reg(CFG_MAX_CHARS, 10'd1023);
		run_random(63, 0, 150, 40);

		write_reg(CFG_MAX_BYTES, 10'd1);
		write_reg(CFG_MAX_CHARS, 10'd1);
		run_random(0, 63, 120, 3);

		write_reg(CFG_MAX_BYTES, 10'd20);
		write_reg(CFG_MAX_CHARS, 10'd8);
		run_random(28, 28, 200, 12);

		write_reg(CFG_MAX_BYTES, 10'd0);
		run_random(0, 0, 40, 6);

		write_reg(CFG_MAX_BYTES, LIMIT_W'($urandom_range(80, 4)));
		write_reg(CFG_MAX_CHARS, LIMIT_W'($urandom_range(30, 2)));
		write_reg(CFG_UNMAPPED, '0);
		run_random(28, 28, 150, 20);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
sv/utv_pkg.sv
sv/utv_decode.sv
sv/utv_verdict.sv
sv/utf8_text_validator_core.sv
bench/testbench.sv
